### sv/srxo_pkg.sv
// shared types, constants and substitution table for the block obfuscator
package srxo_pkg;

  localparam int LEN_W      = 24;
  localparam int MSG_LEN_W  = 24;
  localparam int KEY_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int BLK_BYTES  = 16;
  localparam int POS_W      = $clog2(BLK_BYTES);
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] CFG_MSG_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3    = 3'd4;

  // header fields
  localparam logic [15:0] HDR_MAGIC = 16'd29795;
  localparam logic [7:0]  HDR_VER   = 8'd3;
  localparam logic [7:0]  HDR_ZERO  = 8'd0;
  localparam logic [2:0]  HDR_LAST  = 3'd5;

  typedef struct packed {
    logic                          has_hdr;
    logic [POS_W-1:0]              pad;
    logic                          has_blk;
    logic                          done;
    logic [0:BLK_BYTES-1][7:0]     blk;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  localparam logic [0:255][7:0] SBOX = {
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox_fwd(input logic [7:0] x);
    return SBOX[x];
  endfunction

endpackage

### sv/sbox_rotate_xor_block_obfuscator_core.sv
// top level of the s-box, rotate and xor block obfuscator
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------------------
//   in      | sink      | in_valid / in_stall   | in_data_byte
//   out     | source    | out_valid / out_stall | out_byte, out_run_last, out_message_done
//   cfg     | sink      | cfg_we                | cfg_index, cfg_wdata
//
// cycles: the front takes one payload byte per cycle while in_stall is low; the back
//   sends one byte per cycle while out_stall is low and a job waits, so a message of n
//   bytes leaves as 6 + 16*ceil(n/16) bytes and the output port sets the sustained rate
//   (one output byte per clock while not stalled); with the queue empty, a job's first
//   byte is written into the queue and then into the registered output byte
// reset: synchronous, active low; clears counters, job queue and output valid,
//   block storage holds no reset value and needs no clearing pass
// stalls: in_stall rises only while the four-entry job queue is full; out_stall
//   holds the registered output byte while the back keeps the queue head
module sbox_rotate_xor_block_obfuscator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_data_byte,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_byte,
  output logic                              out_run_last,
  output logic                              out_message_done,
  // config write port
  input  logic                              cfg_we,
  input  logic [srxo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srxo_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import srxo_pkg::*;

  // config registers
  logic [MSG_LEN_W-1:0] msg_len_r;
  logic [KEY_W-1:0]     key0_r, key1_r, key2_r, key3_r;

  // front to queue to back
  logic       push, pop;
  q_entry_t   push_entry, head;
  q_stat_t    q_stat;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_len_r <= MSG_LEN_W'(1);
      key0_r    <= '0;
      key1_r    <= '0;
      key2_r    <= '0;
      key3_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MSG_LEN: msg_len_r <= cfg_wdata[MSG_LEN_W-1:0];
        CFG_KEY0:    key0_r    <= cfg_wdata[KEY_W-1:0];
        CFG_KEY1:    key1_r    <= cfg_wdata[KEY_W-1:0];
        CFG_KEY2:    key2_r    <= cfg_wdata[KEY_W-1:0];
        CFG_KEY3:    key3_r    <= cfg_wdata[KEY_W-1:0];
        default:     ;
      endcase
    end
  end

  // front: substitutes each byte, builds the block and the header job,
  // applies the rotate and key xor as the block is queued
  srxo_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .len          (LEN_W'(msg_len_r)),
    .key0         (key0_r),
    .key1         (key1_r),
    .key2         (key2_r),
    .key3         (key3_r),
    .q_full       (q_stat.full),
    .push         (push),
    .push_entry   (push_entry)
  );

  // job queue decouples intake from the byte serializer
  srxo_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  // back: walks header bytes then block bytes, flags the last byte of each job
  srxo_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_empty          (q_stat.empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_run_last     (out_run_last),
    .out_message_done (out_message_done)
  );

endmodule

### sv/srxo_front.sv
// front end: substitution, block gathering, padding and key mixing
module srxo_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_data_byte,
  input  logic [srxo_pkg::LEN_W-1:0]    len,
  input  logic [srxo_pkg::KEY_W-1:0]    key0,
  input  logic [srxo_pkg::KEY_W-1:0]    key1,
  input  logic [srxo_pkg::KEY_W-1:0]    key2,
  input  logic [srxo_pkg::KEY_W-1:0]    key3,
  input  logic                          q_full,
  output logic                          push,
  output srxo_pkg::q_entry_t            push_entry
);
  import srxo_pkg::*;

  logic [POS_W-1:0]         pos_r, pos_nxt;
  logic [LEN_W-1:0]         taken_r, taken_nxt;
  logic [7:0]               store_r [BLK_BYTES];

  logic                     accept;
  logic [7:0]               sb;
  logic [POS_W-1:0]         pos_inc;
  logic [LEN_W-1:0]         taken_inc;
  logic                     first, ending, wrap;
  logic [7:0]               fill_sb;
  logic [0:BLK_BYTES-1][7:0] blk;
  logic [KEY_W-1:0]         w0, w1, w2, w3;
  logic [KEY_W-1:0]         m0, m1, m2, m3;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign sb        = sbox_fwd(in_data_byte);
  assign pos_inc   = pos_r + POS_W'(1);
  assign taken_inc = taken_r + LEN_W'(1);
  assign first     = (taken_r == '0);
  assign ending    = (taken_inc == len);
  assign wrap      = (pos_inc == '0);
  // every fill byte is the s-box image of 16 minus the first fill position
  assign fill_sb   = sbox_fwd({{(8-POS_W){1'b0}}, POS_W'(0) - pos_inc});

  always_comb begin
    for (int i = 0; i < BLK_BYTES; i++) begin
      if (POS_W'(i) < pos_r) begin
        blk[i] = store_r[i];
      end else if (POS_W'(i) == pos_r) begin
        blk[i] = sb;
      end else begin
        blk[i] = fill_sb;
      end
    end
  end

  assign w0 = {blk[0],  blk[1],  blk[2],  blk[3]};
  assign w1 = {blk[4],  blk[5],  blk[6],  blk[7]};
  assign w2 = {blk[8],  blk[9],  blk[10], blk[11]};
  assign w3 = {blk[12], blk[13], blk[14], blk[15]};

  assign m0 = w0 ^ key0;
  assign m1 = {w1[23:0], w1[31:24]} ^ key1;
  assign m2 = {w2[15:0], w2[31:16]} ^ key2;
  assign m3 = {w3[7:0],  w3[31:8]}  ^ key3;

  assign push = accept && (first || ending || wrap);

  always_comb begin
    push_entry.has_hdr = first;
    push_entry.pad     = POS_W'(0) - len[POS_W-1:0];
    push_entry.has_blk = ending || wrap;
    push_entry.done    = ending;
    push_entry.blk     = {m0, m1, m2, m3};
  end

  assign pos_nxt   = ending ? '0 : pos_inc;
  assign taken_nxt = ending ? '0 : taken_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      taken_r <= '0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      taken_r <= taken_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      store_r[pos_r] <= sb;
    end
  end

endmodule

### sv/srxo_queue.sv
// short fifo of pending header and block jobs between front and back
module srxo_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  srxo_pkg::q_entry_t   push_entry,
  input  logic                 pop,
  output srxo_pkg::q_entry_t   head,
  output srxo_pkg::q_stat_t    q_stat
);
  import srxo_pkg::*;

  q_entry_t            q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]  cnt_r, cnt_nxt;

  assign head         = q_r[rd_ptr_r];
  assign q_stat.empty = (cnt_r == '0);
  assign q_stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

### sv/srxo_back.sv
// back end: serializes header and block jobs into the output byte stream
module srxo_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  srxo_pkg::q_entry_t   head,
  input  logic                 q_empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 out_run_last,
  output logic                 out_message_done
);
  import srxo_pkg::*;

  logic [POS_W-1:0] cnt_r;
  logic             hdr_done_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r, out_done_r;

  logic             load, emit, in_hdr, last;
  logic [7:0]       hdr_byte, sel_byte;

  always_comb begin
    unique case (cnt_r[2:0])
      3'd0:    hdr_byte = HDR_MAGIC[15:8];
      3'd1:    hdr_byte = HDR_MAGIC[7:0];
      3'd2:    hdr_byte = HDR_VER;
      3'd3:    hdr_byte = {{(8-POS_W){1'b0}}, head.pad};
      3'd4:    hdr_byte = HDR_ZERO;
      3'd5:    hdr_byte = HDR_VER;
      default: hdr_byte = HDR_ZERO;
    endcase
  end

  assign load     = !out_valid_r || !out_stall;
  assign emit     = load && !q_empty;
  assign in_hdr   = head.has_hdr && !hdr_done_r;
  assign last     = in_hdr ? (cnt_r[2:0] == HDR_LAST && !head.has_blk) : (cnt_r == '1);
  assign sel_byte = in_hdr ? hdr_byte : head.blk[cnt_r];
  assign pop      = emit && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      hdr_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= emit;
      end
      if (emit) begin
        if (pop) begin
          cnt_r      <= '0;
          hdr_done_r <= 1'b0;
        end else if (in_hdr && cnt_r[2:0] == HDR_LAST) begin
          cnt_r      <= '0;
          hdr_done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= sel_byte;
      out_last_r <= last;
      out_done_r <= last && head.done;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_run_last     = out_last_r;
  assign out_message_done = out_done_r;

endmodule

### sv/srxo_checker.sv
// port-level checks for the block obfuscator, bound to the top level
module srxo_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [7:0]                        out_byte,
  input logic                              out_run_last,
  input logic                              out_message_done
);

  // a stalled result holds its byte and flags
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(out_run_last) && $stable(out_message_done))
    else $error("stalled output transfer changed");

  // end of message always closes the run of its input byte
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_done |-> out_run_last)
    else $error("message_done without run_last");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // reset empties the job queue, so intake is open
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind sbox_rotate_xor_block_obfuscator_core srxo_checker u_chk (.*);
